// ===== src/urbq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbq_pkg
// Shared types, action codes and default sizes for the UART ring queues.
// ----------------------------------------------------------------------------
package urbq_pkg;

	localparam int TX_DEPTH_DEF = 128;
	localparam int RX_DEPTH_DEF = 128;

	localparam logic [2:0] ACT_TX_WRITE   = 3'd0;
	localparam logic [2:0] ACT_HOLD_EMPTY = 3'd1;
	localparam logic [2:0] ACT_RX_BYTE    = 3'd2;
	localparam logic [2:0] ACT_RX_READ    = 3'd3;
	localparam logic [2:0] ACT_SPACE      = 3'd4;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data;
		logic [7:0] len;
	} req_t;

	typedef struct packed {
		logic       line_valid;
		logic [7:0] line_byte;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       tx_dropped;
		logic       rx_overwrote;
		logic       space_ok;
		logic       busy_res;
	} res_t;

endpackage

// ===== src/uart_ring_buffer_queues_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_ring_buffer_queues_top
// Transmit and receive ring queues beside a UART, with direct hand-off of a
// byte to an idle transmitter, an overwrite flag (the byte is not queued) on
// a full receive queue and a transmit free-space query.
// The result strobe done rises in the cycle after a request is taken.
// Throughput: one request per cycle; busy is never raised and the receiver
// cannot stall. Each queue has one RAM with a registered read port, and the
// queued byte of a read comes straight from that port in the result cycle.
// Reset clears all pointers, the running flag and the strobe; the queue
// storage is not cleared, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module uart_ring_buffer_queues_top #(
	parameter int TX_DEPTH = urbq_pkg::TX_DEPTH_DEF,
	parameter int RX_DEPTH = urbq_pkg::RX_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  urbq_pkg::req_t req,
	output logic           done,
	output urbq_pkg::res_t res
);

	localparam int TX_PW = $clog2(TX_DEPTH);
	localparam int RX_PW = $clog2(RX_DEPTH);
	localparam int CW    = (TX_PW + 1 > 8) ? TX_PW + 1 : 8;

	logic [TX_PW-1:0] tx_head_q, tx_tail_q, tx_head_nx, tx_tail_nx;
	logic [RX_PW-1:0] rx_head_q, rx_tail_q, rx_head_nx, rx_tail_nx;
	logic             tx_busy_q;

	logic             accept;
	logic             tx_full, tx_empty, rx_full, rx_empty;
	logic             tx_we, tx_re, rx_we, rx_re;
	logic             direct, dropped, overwrote, tx_idle, space;
	logic [TX_PW:0]   tx_count, tx_room;
	logic [7:0]       tx_rdata, rx_rdata;

	logic             done_q, line_valid_q, line_ram_q, rx_valid_q;
	logic             tx_dropped_q, rx_overwrote_q, space_ok_q;
	logic [7:0]       line_data_q;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign tx_head_nx = (tx_head_q == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
	assign tx_tail_nx = (tx_tail_q == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;
	assign rx_head_nx = (rx_head_q == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
	assign rx_tail_nx = (rx_tail_q == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;

	assign tx_full  = (tx_head_nx == tx_tail_q);
	assign tx_empty = (tx_head_q == tx_tail_q);
	assign rx_full  = (rx_head_nx == rx_tail_q);
	assign rx_empty = (rx_head_q == rx_tail_q);

	assign tx_count = (tx_head_q >= tx_tail_q)
		? {1'b0, tx_head_q} - {1'b0, tx_tail_q}
		: {1'b0, tx_head_q} + (TX_PW + 1)'(TX_DEPTH) - {1'b0, tx_tail_q};
	assign tx_room  = (TX_PW + 1)'(TX_DEPTH - 1) - tx_count;

	always_comb begin
		tx_we     = 1'b0;
		tx_re     = 1'b0;
		rx_we     = 1'b0;
		rx_re     = 1'b0;
		direct    = 1'b0;
		dropped   = 1'b0;
		overwrote = 1'b0;
		tx_idle   = 1'b0;
		space     = 1'b0;
		case (req.action)
			urbq_pkg::ACT_TX_WRITE: begin
				if (tx_full) begin
					dropped = 1'b1;
				end else if (tx_busy_q) begin
					tx_we = 1'b1;
				end else begin
					direct = 1'b1;
				end
			end
			urbq_pkg::ACT_HOLD_EMPTY: begin
				if (!tx_empty) begin
					tx_re = 1'b1;
				end else begin
					tx_idle = 1'b1;
				end
			end
			urbq_pkg::ACT_RX_BYTE: begin
				rx_we     = 1'b1;
				overwrote = rx_full;
			end
			urbq_pkg::ACT_RX_READ: begin
				rx_re = ~rx_empty;
			end
			urbq_pkg::ACT_SPACE: begin
				space = (CW'(tx_room) >= CW'(req.len));
			end
			default: begin
			end
		endcase
	end

	urbq_ram #(
		.WIDTH(8),
		.DEPTH(TX_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (accept & tx_we),
		.waddr(tx_head_q),
		.wdata(req.data),
		.re   (accept & tx_re),
		.raddr(tx_tail_q),
		.rdata(tx_rdata)
	);

	urbq_ram #(
		.WIDTH(8),
		.DEPTH(RX_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (accept & rx_we),
		.waddr(rx_head_q),
		.wdata(req.data),
		.re   (accept & rx_re),
		.raddr(rx_tail_q),
		.rdata(rx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q      <= '0;
			tx_tail_q      <= '0;
			rx_head_q      <= '0;
			rx_tail_q      <= '0;
			tx_busy_q      <= 1'b0;
			done_q         <= 1'b0;
			line_valid_q   <= 1'b0;
			line_ram_q     <= 1'b0;
			rx_valid_q     <= 1'b0;
			tx_dropped_q   <= 1'b0;
			rx_overwrote_q <= 1'b0;
			space_ok_q     <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				if (tx_we) begin
					tx_head_q <= tx_head_nx;
				end
				if (tx_re) begin
					tx_tail_q <= tx_tail_nx;
				end
				if (rx_we && !rx_full) begin
					rx_head_q <= rx_head_nx;
				end
				if (rx_re) begin
					rx_tail_q <= rx_tail_nx;
				end
				if (direct) begin
					tx_busy_q <= 1'b1;
				end else if (tx_idle) begin
					tx_busy_q <= 1'b0;
				end
				line_valid_q   <= direct | tx_re;
				line_ram_q     <= tx_re;
				rx_valid_q     <= rx_re;
				tx_dropped_q   <= dropped;
				rx_overwrote_q <= overwrote;
				space_ok_q     <= space;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_data_q <= req.data;
		end
	end

	assign done = done_q;

	always_comb begin
		res              = '0;
		res.line_valid   = line_valid_q;
		res.line_byte    = line_valid_q ? (line_ram_q ? tx_rdata : line_data_q) : 8'd0;
		res.rx_valid     = rx_valid_q;
		res.rx_byte      = rx_valid_q ? rx_rdata : 8'd0;
		res.tx_dropped   = tx_dropped_q;
		res.rx_overwrote = rx_overwrote_q;
		res.space_ok     = space_ok_q;
		res.busy_res     = tx_busy_q;
	end

endmodule

// ===== src/urbq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module urbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
